[hdl/spq_pkg.sv]
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic               func;
        logic signed [31:0] item_value;
        logic        [15:0] item_priority;
    } spq_req_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic               popped_valid;
        logic        [1:0]  status;
        logic        [4:0]  entry_count;
    } spq_rsp_t;

    // One stored entry.
    typedef struct packed {
        logic        [15:0] priority_key;
        logic signed [31:0] value;
    } spq_slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_OUT,
        ST_INS_CMP,
        ST_INS_PUT
    } spq_state_t;

endpackage

[hdl/sorted_priority_queue_unit.sv]
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-----------------------------------------
// request  | in        | req_valid/req_ready  | req : spq_req_t (func, value, priority)
// response | out       | rsp_valid/rsp_ready  | rsp : spq_rsp_t (value, valid, status, count)
//
// A pop on an empty queue or an insert on a full one is answered from idle, and a
// pop returns the front entry from ST_POP_OUT. An insert walks back from the tail
// in ST_INS_CMP, moving up each held entry whose priority is not below the new one
// until all have moved or a compare meets a lower one, then writes the new entry in
// ST_INS_PUT; the registered-read entry RAM paces the walk at one entry per cycle.
// Reset clears only pointers, count and control; the RAM holds garbage until
// written and its data is never used beyond the held entries, so no clearing pass runs.
// A request is taken only while idle with the response register empty or
// draining; a stalled response holds in its register.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  spq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output spq_rsp_t rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // The entries live in a ring: head_reg points at the front entry and
    // tail_reg at the first free slot, so a pop never moves data.
    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        ptr_next = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
        ptr_prev = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
    endfunction

    spq_state_t     state_reg,  state_next;
    logic [AW-1:0]  head_reg,   head_next;
    logic [AW-1:0]  tail_reg,   tail_next;
    logic [CW-1:0]  count_reg,  count_next;
    logic [AW-1:0]  cursor_reg, cursor_next;   // slot being filled
    logic [AW-1:0]  rdptr_reg,  rdptr_next;    // slot whose data arrives now
    logic [CW-1:0]  left_reg,   left_next;     // entries still below cursor
    spq_req_t       hold_reg,   hold_next;     // request under way
    spq_rsp_t       rsp_reg,    rsp_next;
    logic           rsp_valid_reg, rsp_valid_next;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    spq_slot_t      wr_slot;
    logic [AW-1:0]  rd_addr;
    spq_slot_t      rd_slot;
    logic           accept;

    spq_ram #(
        .WIDTH ($bits(spq_slot_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_slot),
        .rd_addr (rd_addr),
        .rd_data (rd_slot)
    );

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        rdptr_reg  <= rdptr_next;
        left_reg   <= left_next;
        hold_reg   <= hold_next;
        rsp_reg    <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        rdptr_next     = rdptr_reg;
        left_next      = left_reg;
        hold_next      = hold_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        wr_en   = 1'b0;
        wr_addr = cursor_reg;
        wr_slot = '{priority_key: hold_reg.item_priority, value: hold_reg.item_value};
        // Prefetch the entry below the one arriving now.
        rd_addr = ptr_prev(rdptr_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                // Start the read a request will need: front for pop, last for insert.
                rd_addr = (req.func == FUNC_POP) ? head_reg : ptr_prev(tail_reg);
                if (accept)
                begin
                    hold_next = req;
                    if (req.func == FUNC_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next = '{popped_value: '0, popped_valid: 1'b0,
                                         status: STATUS_EMPTY,
                                         entry_count: 5'(count_reg)};
                            rsp_valid_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_POP_OUT;
                        end
                    end
                    else if (count_reg == CW'(QUEUE_DEPTH))
                    begin
                        // Drop the insert and report full.
                        rsp_next = '{popped_value: '0, popped_valid: 1'b0,
                                     status: STATUS_FULL,
                                     entry_count: 5'(count_reg)};
                        rsp_valid_next = 1'b1;
                    end
                    else
                    begin
                        cursor_next = tail_reg;
                        rdptr_next  = ptr_prev(tail_reg);
                        left_next   = count_reg;
                        state_next  = (count_reg == '0) ? ST_INS_PUT : ST_INS_CMP;
                    end
                end
            end

            ST_POP_OUT:
            begin
                // Front entry has arrived: advance head and return it.
                head_next  = ptr_next(head_reg);
                count_next = count_reg - CW'(1);
                rsp_next   = '{popped_value: rd_slot.value, popped_valid: 1'b1,
                               status: STATUS_OK,
                               entry_count: 5'(count_reg - CW'(1))};
                rsp_valid_next = 1'b1;
                state_next = ST_IDLE;
            end

            ST_INS_CMP:
            begin
                // Move up every entry whose priority is not below the new one,
                // so the new entry lands ahead of all equal priorities.
                if (rd_slot.priority_key >= hold_reg.item_priority)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = cursor_reg;
                    wr_slot     = rd_slot;
                    cursor_next = rdptr_reg;
                    rdptr_next  = ptr_prev(rdptr_reg);
                    left_next   = left_reg - CW'(1);
                    if (left_reg == CW'(1))
                    begin
                        state_next = ST_INS_PUT;
                    end
                end
                else
                begin
                    state_next = ST_INS_PUT;
                end
            end

            ST_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = cursor_reg;
                tail_next  = ptr_next(tail_reg);
                count_next = count_reg + CW'(1);
                rsp_next   = '{popped_value: '0, popped_valid: 1'b0,
                               status: STATUS_OK,
                               entry_count: 5'(count_reg + CW'(1))};
                rsp_valid_next = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/spq_ram.sv]
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
